/* rtl/ptts_pkg.sv */
// Shared types and constants for the periodic task tick scheduler.
// Used by the top level; the slot RAM is generic and stands alone.
`default_nettype none

package ptts_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int SLOT_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int USED_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 8;
  localparam int SLOT_OUT_W = 3;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (MASK_W + 1 + SLOT_OUT_W + TIME_W);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // One slot memory word: reload value and next due time side by side.
  typedef struct packed {
    logic [TIME_W-1:0] next_due;
    logic [TIME_W-1:0] period;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

/* rtl/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler: tick time, slot table in RAM, command sequencer.
// Depends on ptts_pkg and ptts_ram.
//
// One item is one command (tick, add, clear) and yields exactly one result item.
// Slot periods and next due times live in a single-port-read slot RAM, so a
// tick walks the table one slot per cycle. A new item is taken only in the idle
// state, after the current item has produced its result. The result sits in an
// output register; a stalled result holds the block after it finishes the
// current item.
`default_nettype none

module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [31:0] period, [32] task_present, [39:33] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] fire_mask, [8] status, [11:9] slot, [43:12] current_time, [47:44] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       cnt_r;
  logic [TIME_W-1:0]       tick_time_r;
  logic [USED_W-1:0]       slots_used_r;
  logic [MAX_TASKS-1:0]    active_r;
  logic [MASK_W-1:0]       mask_r;
  logic                    status_r;
  logic [SLOT_OUT_W-1:0]   slot_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  cmd_t                    in_cmd;
  logic [TIME_W-1:0]       in_period;
  logic                    in_present;
  logic                    in_acc;
  logic                    out_free;
  logic                    table_full;
  logic [TIME_W-1:0]       add_period;
  logic                    fire;
  slot_entry_t             rd_entry;
  logic [ENTRY_W-1:0]      ram_rd_data;
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  slot_entry_t             ram_wdata;
  logic                    ram_re;
  logic [SLOT_W-1:0]       ram_raddr;

  assign in_cmd     = cmd_t'(in_tuser);
  assign in_period  = in_tdata[TIME_W-1:0];
  assign in_present = in_tdata[TIME_W];
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = (slots_used_r >= USED_W'(MAX_TASKS));
  assign add_period = in_period - TIME_W'(1);
  assign rd_entry   = slot_entry_t'(ram_rd_data);

  ptts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cmd == CMD_TICK) ? ST_SWEEP : ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read slot cnt_r+1 while slot cnt_r is checked and written back.
  always_comb begin
    in_tready = 1'b0;
    fire      = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state_r)
      ST_IDLE: begin
        // hold off items while reset is applied
        in_tready          = rst_n;
        ram_re             = in_acc && (in_cmd == CMD_TICK);
        ram_we             = in_acc && (in_cmd == CMD_ADD) && !table_full;
        ram_waddr          = slots_used_r[SLOT_W-1:0];
        ram_wdata.period   = add_period;
        ram_wdata.next_due = tick_time_r + add_period;
      end
      ST_SWEEP: begin
        fire               = active_r[cnt_r] && (tick_time_r > rd_entry.next_due);
        ram_we             = fire;
        ram_waddr          = cnt_r;
        ram_wdata.period   = rd_entry.period;
        ram_wdata.next_due = tick_time_r + rd_entry.period;
        ram_re             = (cnt_r != LAST_SLOT);
        ram_raddr          = cnt_r + SLOT_W'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_time_r  <= '0;
      slots_used_r <= '0;
      active_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_acc) begin
        mask_r   <= '0;
        status_r <= 1'b0;
        slot_r   <= '0;
        cnt_r    <= '0;
        unique case (in_cmd)
          CMD_ADD: begin
            if (table_full) begin
              status_r <= 1'b1;
            end else begin
              slot_r                                <= SLOT_OUT_W'(slots_used_r);
              active_r[slots_used_r[SLOT_W-1:0]]    <= in_present;
              slots_used_r                          <= slots_used_r + USED_W'(1);
            end
          end
          CMD_CLEAR: begin
            tick_time_r  <= '0;
            slots_used_r <= '0;
            active_r     <= '0;
          end
          CMD_TICK, CMD_NOP: begin
          end
          default: begin
          end
        endcase
      end

      if (state_r == ST_SWEEP) begin
        for (int j = 0; j < MASK_W; j++) begin
          if (j < MAX_TASKS && fire && int'(cnt_r) == j) begin
            mask_r[j] <= 1'b1;
          end
        end
        cnt_r <= cnt_r + SLOT_W'(1);
        // advance time once every slot has been checked
        if (cnt_r == LAST_SLOT) begin
          tick_time_r <= tick_time_r + TIME_W'(1);
        end
      end

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_tdata_r <= {{OUT_PAD_W{1'b0}}, tick_time_r, slot_r, status_r, mask_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot RAM read and write hit the same entry");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= USED_W'(MAX_TASKS))
    else $error("slot count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && cnt_r == LAST_SLOT) |=> (state_r == ST_DONE))
    else $error("tick sweep did not finish after the last slot");

endmodule

`default_nettype wire

/* rtl/ptts_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ptts_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* dv/periodic_task_tick_scheduler_tb.sv */
// Self-checking bench for the periodic task tick scheduler: directed and random
// command streams, a local predictor of the slot table and tick time, random idling.
// Depends on ptts_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_tb
  import ptts_pkg::*;
();

  // Result layout as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic [TIME_W-1:0]     now;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  status;
    logic [MASK_W-1:0]     fire_mask;
  } tick_report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [31:0] period, [32] task_present, [39:33] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [1:0] command
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] fire_mask, [8] status, [11:9] slot, [43:12] current_time, [47:44] zero
  logic [OUT_DATA_W-1:0] out_tdata;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  mismatches    = 0;
  int unsigned  items_sent    = 0;
  tick_report_t due_reports[$];

  // Predicted scheduler state
  logic [TIME_W-1:0] sched_time;
  logic [TIME_W-1:0] sched_reload [MAX_TASKS];
  logic [TIME_W-1:0] sched_due    [MAX_TASKS];
  logic              sched_armed  [MAX_TASKS];
  int unsigned       sched_filled;

  periodic_task_tick_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_schedule();
    sched_time   = '0;
    sched_filled = 0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      sched_reload[i] = '0;
      sched_due[i]    = '0;
      sched_armed[i]  = 1'b0;
    end
  endfunction

  function automatic tick_report_t advance_schedule(cmd_t cmd, logic [TIME_W-1:0] period,
                                                    logic present);
    tick_report_t      r;
    logic [TIME_W-1:0] p;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (sched_armed[i] && sched_time > sched_due[i]) begin
            sched_due[i] = sched_time + sched_reload[i];
            if (i < MASK_W) r.fire_mask[i] = 1'b1;
          end
        end
        sched_time = sched_time + 1'b1;
      end
      CMD_ADD: begin
        if (sched_filled < MAX_TASKS) begin
          p = period - 1'b1;
          sched_reload[sched_filled] = p;
          sched_due[sched_filled]    = sched_time + p;
          sched_armed[sched_filled]  = present;
          r.slot = sched_filled[SLOT_OUT_W-1:0];
          sched_filled++;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CLEAR: clear_schedule();
      default: ;
    endcase
    r.now = sched_time;
    return r;
  endfunction

  // Mostly short periods so slots fire often; some zero, random and near-wrap ones
  function automatic logic [TIME_W-1:0] pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Valid stays high after an accept; the next call either keeps it or drops it for a gap
  task automatic send_item(cmd_t cmd, logic [TIME_W-1:0] period, logic present);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W - TIME_W - 1){1'b0}}, present, period};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due_reports.push_back(advance_schedule(cmd, period, present));
    if (cmd != CMD_NOP) items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tick_report_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = tick_report_t'(out_tdata[OUT_DATA_W-OUT_PAD_W-1:0]);
      if (due_reports.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result item: mask %h status %0d slot %0d time %0d",
                   got.fire_mask, got.status, got.slot, got.now);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display({"mismatch (expected/actual): mask %h/%h status %0d/%0d ",
                      "slot %0d/%0d time %0d/%0d"},
                     want.fire_mask, got.fire_mask, want.status, got.status,
                     want.slot, got.slot, want.now, got.now);
          mismatches++;
        end
      end
    end
  end

  // Fill every slot with edge periods, then overflow the table
  task automatic test_table_fill();
    send_item(CMD_TICK, '0, 1'b0);
    send_item(CMD_CLEAR, '0, 1'b0);
    send_item(CMD_ADD, 32'h0000_0000, 1'b1);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_ADD, 32'd1, 1'b0);
    send_item(CMD_ADD, 32'd1, 1'b1);
    send_item(CMD_ADD, 32'd2, 1'b1);
    send_item(CMD_ADD, 32'd3, 1'b1);
    send_item(CMD_ADD, 32'd1, 1'b1);
    send_item(CMD_ADD, 32'd5, 1'b1);
    send_item(CMD_ADD, 32'd7, 1'b1);
  endtask

  task automatic test_tick_firing();
    repeat (6) send_item(CMD_TICK, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic test_unknown_and_clear();
    send_item(CMD_NOP, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_NOP, 32'h0000_0000, 1'b0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Episodes: usually a clear, load the table, then a run of ticks with a little noise
  task automatic test_random_schedule(int unsigned n_items);
    int unsigned target;
    int unsigned n_adds;
    int unsigned n_ticks;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(9) != 0) send_item(CMD_CLEAR, $urandom, 1'($urandom_range(1)));
      n_adds = $urandom_range(1, 10);
      repeat (n_adds) send_item(CMD_ADD, pick_period(), $urandom_range(99) < 85);
      n_ticks = $urandom_range(10, 60);
      repeat (n_ticks) begin
        case ($urandom_range(19))
          0:       send_item(CMD_NOP, $urandom, 1'($urandom_range(1)));
          1:       send_item(CMD_ADD, pick_period(), 1'($urandom_range(1)));
          default: send_item(CMD_TICK, $urandom, 1'($urandom_range(1)));
        endcase
      end
    end
  endtask

  initial begin
    clear_schedule();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 57;
    test_table_fill();
    test_tick_firing();
    test_unknown_and_clear();
    test_random_schedule(600);
    // hold the input until the output side has caught up
    drain_results();

    send_idle_pct = 57;
    recv_idle_pct = 26;
    test_random_schedule(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_schedule(600);
    drain_results();

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("periodic_task_tick_scheduler_tb OK");
    end else begin
      $display("periodic_task_tick_scheduler_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("periodic_task_tick_scheduler_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ptts_pkg.sv
rtl/ptts_ram.sv
rtl/periodic_task_tick_scheduler.sv
dv/periodic_task_tick_scheduler_tb.sv
